/* rtl/tam2_pkg.sv */
package tam2_pkg;

    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 8;
    localparam int NLANE      = 4;

    localparam int EDGE_W  = COORD_BITS + 1;
    localparam int PROD_W  = 2 * EDGE_W;
    localparam int DET_W   = 2 * COORD_BITS + 3;
    localparam int FWD_W   = PROD_W + 2;
    localparam int NUM1_W  = DET_W + FRAC_BITS;
    localparam int NUM3_W  = EDGE_W + 1 + 2 * FRAC_BITS;
    localparam int NUM_W   = (NUM1_W > NUM3_W) ? NUM1_W : NUM3_W;
    localparam int REM_W   = (NUM_W > DET_W + COORD_BITS) ? NUM_W : DET_W + COORD_BITS;
    localparam int NCELL   = COORD_BITS + 1;

    localparam logic [1:0] OP_FWD = 2'd0;
    localparam logic [1:0] OP_INV = 2'd1;
    localparam logic [1:0] OP_DET = 2'd2;
    localparam logic [1:0] OP_MAT = 2'd3;

    localparam logic [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    typedef struct packed {
        logic [1:0]                   op;
        logic signed [COORD_BITS-1:0] v0x;
        logic signed [COORD_BITS-1:0] v0y;
        logic signed [COORD_BITS-1:0] v1x;
        logic signed [COORD_BITS-1:0] v1y;
        logic signed [COORD_BITS-1:0] v2x;
        logic signed [COORD_BITS-1:0] v2y;
        logic signed [COORD_BITS-1:0] px;
        logic signed [COORD_BITS-1:0] py;
    } tam2_in_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] res_a;
        logic signed [COORD_BITS-1:0] res_b;
        logic signed [COORD_BITS-1:0] res_c;
        logic signed [COORD_BITS-1:0] res_d;
        logic [DET_W-1:0]             det_abs;
        logic                         singular;
        logic                         saturated;
    } tam2_out_t;

    // Partial state of the four quotient lanes as it moves down the divider cells.
    typedef struct packed {
        logic [NLANE-1:0][REM_W-1:0]      rem;
        logic [NLANE-1:0][COORD_BITS-1:0] quo;
        logic [NLANE-1:0]                 neg;
        logic [NLANE-1:0]                 ovf;
        logic [DET_W-1:0]                 dvs;
        logic [1:0]                       op;
        logic                             sing;
        logic [COORD_BITS-1:0]            fwd_a;
        logic [COORD_BITS-1:0]            fwd_b;
        logic                             fwd_sat;
    } tam2_div_t;

    // Returns {saturated, value} for a wide signed value clipped to the coordinate range.
    function automatic logic [COORD_BITS:0] clip_wide(input logic [FWD_W-1:0] v);
        logic [FWD_W-COORD_BITS:0] upper;
        logic                      fits;
        upper = v[FWD_W-1:COORD_BITS-1];
        fits  = (&upper) | (~|upper);
        if (fits) begin
            clip_wide = {1'b0, v[COORD_BITS-1:0]};
        end else begin
            clip_wide = {1'b1, v[FWD_W-1] ? COORD_MIN : COORD_MAX};
        end
    endfunction

endpackage

/* rtl/tam2_prep.sv */
module tam2_prep (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  tam2_pkg::tam2_in_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output tam2_pkg::tam2_div_t out_data
);
    import tam2_pkg::*;

    localparam logic [FWD_W-1:0] FRAC_MASK = (FWD_W'(1) << FRAC_BITS) - FWD_W'(1);

    logic en1, en2, en3;
    logic v1_reg, v2_reg, v3_reg;

    // Stage 1: edge vectors and the point relative to v0.
    logic [1:0]                   op1_reg;
    logic signed [EDGE_W-1:0]     b00_1_reg, b01_1_reg, b10_1_reg, b11_1_reg;
    logic signed [EDGE_W-1:0]     qx1_reg, qy1_reg, px1_reg, py1_reg;
    logic signed [COORD_BITS-1:0] v0x1_reg, v0y1_reg;

    // Stage 2: all products.
    logic [1:0]                   op2_reg;
    logic signed [EDGE_W-1:0]     b00_2_reg, b01_2_reg, b10_2_reg, b11_2_reg;
    logic signed [COORD_BITS-1:0] v0x2_reg, v0y2_reg;
    logic signed [PROD_W-1:0]     p00px_reg, p01py_reg, p10px_reg, p11py_reg;
    logic signed [PROD_W-1:0]     p00p11_reg, p01p10_reg;
    logic signed [PROD_W-1:0]     p11qx_reg, p01qy_reg, p00qy_reg, p10qx_reg;

    // Stage 3: determinant, forward map and division setup.
    tam2_div_t div_next, div_reg;

    logic signed [DET_W-1:0] det;
    logic [DET_W-1:0]        det_mag;
    logic signed [FWD_W-1:0] fsum_a, fsum_b, ftq_a, ftq_b;
    logic [COORD_BITS:0]     fclip_a, fclip_b;
    logic signed [DET_W-1:0] inv0, inv1;
    logic [NLANE-1:0][NUM_W-1:0] num;

    assign en3      = !v3_reg || out_ready;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            op1_reg   <= in_data.op;
            b00_1_reg <= {in_data.v1x[COORD_BITS-1], in_data.v1x}
                       - {in_data.v0x[COORD_BITS-1], in_data.v0x};
            b01_1_reg <= {in_data.v2x[COORD_BITS-1], in_data.v2x}
                       - {in_data.v0x[COORD_BITS-1], in_data.v0x};
            b10_1_reg <= {in_data.v1y[COORD_BITS-1], in_data.v1y}
                       - {in_data.v0y[COORD_BITS-1], in_data.v0y};
            b11_1_reg <= {in_data.v2y[COORD_BITS-1], in_data.v2y}
                       - {in_data.v0y[COORD_BITS-1], in_data.v0y};
            qx1_reg   <= {in_data.px[COORD_BITS-1], in_data.px}
                       - {in_data.v0x[COORD_BITS-1], in_data.v0x};
            qy1_reg   <= {in_data.py[COORD_BITS-1], in_data.py}
                       - {in_data.v0y[COORD_BITS-1], in_data.v0y};
            px1_reg   <= {in_data.px[COORD_BITS-1], in_data.px};
            py1_reg   <= {in_data.py[COORD_BITS-1], in_data.py};
            v0x1_reg  <= in_data.v0x;
            v0y1_reg  <= in_data.v0y;
        end
        if (en2) begin
            op2_reg    <= op1_reg;
            b00_2_reg  <= b00_1_reg;
            b01_2_reg  <= b01_1_reg;
            b10_2_reg  <= b10_1_reg;
            b11_2_reg  <= b11_1_reg;
            v0x2_reg   <= v0x1_reg;
            v0y2_reg   <= v0y1_reg;
            p00px_reg  <= PROD_W'(b00_1_reg) * PROD_W'(px1_reg);
            p01py_reg  <= PROD_W'(b01_1_reg) * PROD_W'(py1_reg);
            p10px_reg  <= PROD_W'(b10_1_reg) * PROD_W'(px1_reg);
            p11py_reg  <= PROD_W'(b11_1_reg) * PROD_W'(py1_reg);
            p00p11_reg <= PROD_W'(b00_1_reg) * PROD_W'(b11_1_reg);
            p01p10_reg <= PROD_W'(b01_1_reg) * PROD_W'(b10_1_reg);
            p11qx_reg  <= PROD_W'(b11_1_reg) * PROD_W'(qx1_reg);
            p01qy_reg  <= PROD_W'(b01_1_reg) * PROD_W'(qy1_reg);
            p00qy_reg  <= PROD_W'(b00_1_reg) * PROD_W'(qy1_reg);
            p10qx_reg  <= PROD_W'(b10_1_reg) * PROD_W'(qx1_reg);
        end
        if (en3) begin
            div_reg <= div_next;
        end
    end

    always_comb begin
        det     = DET_W'(p00p11_reg) - DET_W'(p01p10_reg);
        det_mag = det[DET_W-1] ? DET_W'(-det) : DET_W'(det);

        fsum_a = FWD_W'(p00px_reg) + FWD_W'(p01py_reg) + (FWD_W'(v0x2_reg) <<< FRAC_BITS);
        fsum_b = FWD_W'(p10px_reg) + FWD_W'(p11py_reg) + (FWD_W'(v0y2_reg) <<< FRAC_BITS);
        // Arithmetic shift floors; negative values with a nonzero fraction step back up.
        ftq_a = fsum_a >>> FRAC_BITS;
        ftq_b = fsum_b >>> FRAC_BITS;
        if (fsum_a[FWD_W-1] && ((fsum_a & FRAC_MASK) != '0)) ftq_a = ftq_a + FWD_W'(1);
        if (fsum_b[FWD_W-1] && ((fsum_b & FRAC_MASK) != '0)) ftq_b = ftq_b + FWD_W'(1);
        fclip_a = clip_wide(ftq_a);
        fclip_b = clip_wide(ftq_b);

        inv0 = DET_W'(p11qx_reg) - DET_W'(p01qy_reg);
        inv1 = DET_W'(p00qy_reg) - DET_W'(p10qx_reg);
        if (op2_reg == OP_MAT) begin
            num[0] = NUM_W'(b11_2_reg) <<< (2 * FRAC_BITS);
            num[1] = (-NUM_W'(b01_2_reg)) <<< (2 * FRAC_BITS);
            num[2] = (-NUM_W'(b10_2_reg)) <<< (2 * FRAC_BITS);
            num[3] = NUM_W'(b00_2_reg) <<< (2 * FRAC_BITS);
        end else begin
            num[0] = NUM_W'(inv0) <<< FRAC_BITS;
            num[1] = NUM_W'(inv1) <<< FRAC_BITS;
            num[2] = '0;
            num[3] = '0;
        end

        div_next = '0;
        for (int l = 0; l < NLANE; l++) begin
            div_next.rem[l] = REM_W'(num[l][NUM_W-1] ? NUM_W'(-num[l]) : num[l]);
            div_next.neg[l] = num[l][NUM_W-1] ^ det[DET_W-1];
        end
        div_next.dvs     = det_mag;
        div_next.op      = op2_reg;
        div_next.sing    = (det == '0);
        div_next.fwd_a   = fclip_a[COORD_BITS-1:0];
        div_next.fwd_b   = fclip_b[COORD_BITS-1:0];
        div_next.fwd_sat = fclip_a[COORD_BITS] | fclip_b[COORD_BITS];
    end

    assign out_valid = v3_reg;
    assign out_data  = div_reg;

endmodule

/* rtl/tam2_div_cell.sv */
module tam2_div_cell #(
    parameter int SHIFT = 0
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  tam2_pkg::tam2_div_t in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output tam2_pkg::tam2_div_t out_data
);
    import tam2_pkg::*;

    // The first cell tests for a quotient beyond the coordinate range.
    localparam bit IS_TOP = (SHIFT == COORD_BITS);
    localparam int QI     = IS_TOP ? 0 : SHIFT;

    logic             v_reg;
    tam2_div_t        data_next, data_reg;
    logic [REM_W-1:0] trial;
    logic [NLANE-1:0] ge;

    assign in_ready = !v_reg || out_ready;

    always_comb begin
        trial     = REM_W'(in_data.dvs) << SHIFT;
        data_next = in_data;
        for (int l = 0; l < NLANE; l++) begin
            ge[l] = (in_data.rem[l] >= trial);
            if (ge[l]) data_next.rem[l] = in_data.rem[l] - trial;
            if (IS_TOP) begin
                data_next.ovf[l] = ge[l];
            end else begin
                data_next.quo[l][QI] = ge[l];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (in_ready) begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) data_reg <= data_next;
    end

    assign out_valid = v_reg;
    assign out_data  = data_reg;

endmodule

/* rtl/tam2_post.sv */
module tam2_post (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  tam2_pkg::tam2_div_t in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output tam2_pkg::tam2_out_t out_data
);
    import tam2_pkg::*;

    localparam logic [COORD_BITS-1:0] NEG_LIMIT = COORD_MIN;

    logic                             v_reg;
    logic [1:0]                       op_reg;
    tam2_out_t                        res_next, res_reg;
    logic [NLANE-1:0][COORD_BITS-1:0] lane_val;
    logic [NLANE-1:0]                 lane_sat;
    logic                             div_ok;

    assign in_ready = !v_reg || out_ready;

    always_comb begin
        for (int l = 0; l < NLANE; l++) begin
            if (in_data.neg[l]) begin
                lane_sat[l] = in_data.ovf[l] || (in_data.quo[l] > NEG_LIMIT);
                lane_val[l] = lane_sat[l] ? COORD_MIN : COORD_BITS'(-in_data.quo[l]);
            end else begin
                lane_sat[l] = in_data.ovf[l] || in_data.quo[l][COORD_BITS-1];
                lane_val[l] = lane_sat[l] ? COORD_MAX : in_data.quo[l];
            end
        end

        div_ok   = !in_data.sing;
        res_next = '0;
        res_next.det_abs  = in_data.dvs;
        res_next.singular = in_data.sing;
        case (in_data.op)
            OP_FWD: begin
                res_next.res_a     = in_data.fwd_a;
                res_next.res_b     = in_data.fwd_b;
                res_next.saturated = in_data.fwd_sat;
            end
            OP_INV: begin
                if (div_ok) begin
                    res_next.res_a     = lane_val[0];
                    res_next.res_b     = lane_val[1];
                    res_next.saturated = lane_sat[0] | lane_sat[1];
                end
            end
            OP_MAT: begin
                if (div_ok) begin
                    res_next.res_a     = lane_val[0];
                    res_next.res_b     = lane_val[1];
                    res_next.res_c     = lane_val[2];
                    res_next.res_d     = lane_val[3];
                    res_next.saturated = |lane_sat;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (in_ready) begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            res_reg <= res_next;
            op_reg  <= in_data.op;
        end
    end

    assign out_valid = v_reg;
    assign out_data  = res_reg;

    a_sing_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        v_reg && res_reg.singular && (op_reg == OP_INV || op_reg == OP_MAT)
        |-> res_reg.res_a == '0 && res_reg.res_b == '0 && res_reg.res_c == '0
            && res_reg.res_d == '0 && !res_reg.saturated)
        else $error("singular inverse result is not zero");

    a_cd_only_mat: assert property (@(posedge aclk) disable iff (!aresetn)
        v_reg && op_reg != OP_MAT |-> res_reg.res_c == '0 && res_reg.res_d == '0)
        else $error("lower inverse entries set outside the inverse matrix operation");

    a_det_op_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        v_reg && op_reg == OP_DET |-> res_reg.res_a == '0 && !res_reg.saturated)
        else $error("determinant operation produced a map result");

endmodule

/* rtl/triangle_affine_map_2d_top.sv */
// Affine map of a 2-D triangle in signed Q8.8 fixed point.
// Input channel s_*: one transfer carries an operation code, three vertices and a point.
// Output channel m_*: one transfer per input item, in order, with the mapped point,
// the inverse edge matrix entries, the absolute determinant and the singular and
// saturation flags.
// From input transfer to m_valid an item passes the edge-vector, product and sum
// registers, a row of 17 divider cells, one per quotient test (one overflow test
// plus 16 bits, restoring, four lanes each), and one output register.
// Throughput is one item per cycle while m_ready is high; every stage
// holds its own valid bit, so empty stages keep filling while the receiver stalls,
// and s_ready drops only when every stage holds an item and m_ready is low.
// Reset (aresetn low, synchronous) empties the pipeline; no other state is kept.
module triangle_affine_map_2d_top (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  tam2_pkg::tam2_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output tam2_pkg::tam2_out_t m_data
);
    import tam2_pkg::*;

    logic      vld [NCELL+1];
    logic      rdy [NCELL+1];
    tam2_div_t dat [NCELL+1];

    tam2_prep u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_data),
        .out_valid (vld[0]),
        .out_ready (rdy[0]),
        .out_data  (dat[0])
    );

    for (genvar i = 0; i < NCELL; i++) begin : g_cell
        tam2_div_cell #(
            .SHIFT (COORD_BITS - i)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (vld[i]),
            .in_ready  (rdy[i]),
            .in_data   (dat[i]),
            .out_valid (vld[i+1]),
            .out_ready (rdy[i+1]),
            .out_data  (dat[i+1])
        );
    end

    tam2_post u_post (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (vld[NCELL]),
        .in_ready  (rdy[NCELL]),
        .in_data   (dat[NCELL]),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

    a_stall_only_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled while the output is free");

    a_sing_det: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.singular == (m_data.det_abs == '0))
        else $error("singular flag disagrees with the determinant");

    a_sing_no_sat_det: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.singular |-> m_data.res_c == '0 && m_data.res_d == '0)
        else $error("inverse entries reported for a singular triangle");

endmodule

/* verif/testbench.sv */
module testbench;
    import tam2_pkg::*;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    tam2_in_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    tam2_out_t m_data;

    triangle_affine_map_2d_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    tam2_in_t  pending_tris[$];
    tam2_out_t expected_maps[$];
    int        errors = 0;
    int        accepted = 0;
    int        received = 0;
    int        op_count[4];
    int        singular_seen = 0;
    int        saturated_seen = 0;
    bit        stim_done = 1'b0;
    int        long_hold = 0;

    // Clip a wide signed value to the signed Q8.8 range and note any clipping.
    function automatic logic signed [COORD_BITS-1:0] clamp_q88(input longint v,
                                                               inout bit sat);
        longint hi;
        longint lo;
        hi = (64'sd1 <<< (COORD_BITS - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) begin
            sat = 1'b1;
            return hi[COORD_BITS-1:0];
        end
        if (v < lo) begin
            sat = 1'b1;
            return lo[COORD_BITS-1:0];
        end
        return v[COORD_BITS-1:0];
    endfunction

    // SystemVerilog integer division truncates toward zero, as the hardware must.
    function automatic tam2_out_t map_triangle(input tam2_in_t t);
        tam2_out_t r;
        longint b00, b01, b10, b11, det, adet, one, qx, qy;
        bit sat;
        b00 = longint'(t.v1x) - longint'(t.v0x);
        b01 = longint'(t.v2x) - longint'(t.v0x);
        b10 = longint'(t.v1y) - longint'(t.v0y);
        b11 = longint'(t.v2y) - longint'(t.v0y);
        det = b00 * b11 - b01 * b10;
        adet = (det < 0) ? -det : det;
        one = 64'sd1 <<< FRAC_BITS;
        sat = 1'b0;
        r = '0;
        if (t.op == OP_FWD) begin
            r.res_a = clamp_q88((b00 * t.px + b01 * t.py + longint'(t.v0x) * one) / one, sat);
            r.res_b = clamp_q88((b10 * t.px + b11 * t.py + longint'(t.v0y) * one) / one, sat);
        end else if (t.op == OP_INV && det != 0) begin
            qx = longint'(t.px) - longint'(t.v0x);
            qy = longint'(t.py) - longint'(t.v0y);
            r.res_a = clamp_q88(((b11 * qx - b01 * qy) * one) / det, sat);
            r.res_b = clamp_q88(((b00 * qy - b10 * qx) * one) / det, sat);
        end else if (t.op == OP_MAT && det != 0) begin
            r.res_a = clamp_q88((b11 * one * one) / det, sat);
            r.res_b = clamp_q88((-b01 * one * one) / det, sat);
            r.res_c = clamp_q88((-b10 * one * one) / det, sat);
            r.res_d = clamp_q88((b00 * one * one) / det, sat);
        end
        r.det_abs = adet[DET_W-1:0];
        r.singular = (det == 0);
        r.saturated = sat;
        return r;
    endfunction

    function automatic logic signed [COORD_BITS-1:0] rand_coord(input int mode);
        case (mode)
            0: return COORD_BITS'($urandom);
            1: return COORD_BITS'($urandom_range(0, 2047) - 1024);
            default: return COORD_BITS'($urandom_range(0, 255) - 128);
        endcase
    endfunction

    task automatic add_tri(input logic [1:0] op, input int v0x, v0y, v1x, v1y,
                           v2x, v2y, px, py);
        tam2_in_t t;
        t.op = op;
        t.v0x = COORD_BITS'(v0x); t.v0y = COORD_BITS'(v0y);
        t.v1x = COORD_BITS'(v1x); t.v1y = COORD_BITS'(v1y);
        t.v2x = COORD_BITS'(v2x); t.v2y = COORD_BITS'(v2y);
        t.px = COORD_BITS'(px); t.py = COORD_BITS'(py);
        pending_tris.push_back(t);
    endtask

    task automatic add_random_tri();
        tam2_in_t t;
        int mode;
        mode = $urandom_range(0, 2);
        t.op = 2'($urandom_range(0, 3));
        t.v0x = rand_coord(mode); t.v0y = rand_coord(mode);
        t.v1x = rand_coord(mode); t.v1y = rand_coord(mode);
        t.v2x = rand_coord(mode); t.v2y = rand_coord(mode);
        t.px = rand_coord(mode); t.py = rand_coord(mode);
        // Now and then collapse the triangle so the singular path is hit.
        case ($urandom_range(0, 9))
            0: begin t.v1x = t.v0x; t.v1y = t.v0y; end
            1: begin t.v2x = t.v1x; t.v2y = t.v1y; end
            2: begin
                t.v2x = COORD_BITS'(t.v0x + 2 * (t.v1x - t.v0x));
                t.v2y = COORD_BITS'(t.v0y + 2 * (t.v1y - t.v0y));
            end
            default: ;
        endcase
        pending_tris.push_back(t);
    endtask

    initial begin
        logic [1:0] op;
        for (int k = 0; k < 4; k++) begin
            op = 2'(k);
            add_tri(op, 0, 0, 256, 0, 0, 256, 64, 128);
            add_tri(op, -32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
            add_tri(op, 100, 200, 100, 200, 500, -300, 10, 20);
            add_tri(op, 0, 0, 1, 0, 0, 1, 32767, -32768);
            add_tri(op, 32767, -32768, -32768, 32767, 32767, 32767, -1, -1);
        end
        add_tri(OP_INV, 0, 0, 2, 2, 4, 4, 5, 5);
        add_tri(OP_MAT, 0, 0, 32767, 0, 0, -32768, 0, 0);
        for (int n = 0; n < 1000; n++) add_random_tri();
    end

    // Sender: random gap before each item, valid held until the transfer.
    int send_gap = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_gap <= $urandom_range(0, 14);
        end else if (s_valid && !s_ready) begin
        end else if (s_valid && s_ready && (pending_tris.size() == 0 ||
                     $urandom_range(0, 2) != 0)) begin
            expected_maps.push_back(map_triangle(s_data));
            op_count[s_data.op]++;
            accepted++;
            s_valid <= 1'b0;
            send_gap <= $urandom_range(0, 3) == 0 ? $urandom_range(0, 14) : 0;
            if (pending_tris.size() == 0) stim_done <= 1'b1;
        end else begin
            if (s_valid && s_ready) begin
                expected_maps.push_back(map_triangle(s_data));
                op_count[s_data.op]++;
                accepted++;
            end
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                s_valid <= 1'b0;
            end else if (pending_tris.size() > 0) begin
                s_data <= pending_tris.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
                stim_done <= 1'b1;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off so the pipeline fills.
    int recv_gap = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                received++;
                if (expected_maps.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result %p", $time, m_data);
                end else begin
                    tam2_out_t e;
                    e = expected_maps.pop_front();
                    if (e.singular) singular_seen++;
                    if (e.saturated) saturated_seen++;
                    if (m_data !== e) begin
                        errors++;
                        $display("%0t: mismatch expected %p actual %p", $time, e, m_data);
                    end
                end
            end
            if (accepted >= 40 && long_hold == 0) begin
                long_hold <= 1;
                recv_gap <= 80;
                m_ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                m_ready <= 1'b0;
            end else if (m_valid && m_ready && $urandom_range(0, 2) == 0) begin
                recv_gap <= $urandom_range(0, 14);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        wait (stim_done && expected_maps.size() == 0);
        repeat (40) @(posedge aclk);
        $display("Covered %0d items in, %0d out (ops %0d/%0d/%0d/%0d).",
                 accepted, received, op_count[0], op_count[1], op_count[2], op_count[3]);
        $display("Results included %0d singular and %0d saturated cases.",
                 singular_seen, saturated_seen);
        if (errors == 0 && expected_maps.size() == 0 && received == accepted) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Verification failed");
        $finish;
    end
endmodule
